[hdl/tlent_pkg.sv]
// Shared types and constants of the text line export entabber.
`default_nettype none

package tlent_pkg;

  // Column bound that saturates the line position.
  localparam int unsigned DefMaxColumn = 4095;

  // Character codes.
  localparam logic [7:0] EscChar   = 8'o177;
  localparam logic [7:0] CtrlMask  = 8'o037;
  localparam logic [7:0] SpaceChar = 8'h20;

  // Tab stops every eight columns.
  localparam int unsigned TabStop  = 8;
  localparam int unsigned TabShift = $clog2(TabStop);

  // Output field widths.
  localparam int unsigned TabRunW    = 10;
  localparam int unsigned SpaceRunW  = 12;
  localparam int unsigned LineBytesW = 14;
  localparam int unsigned ByteCntW   = 13;

  // Byte count saturation point, newline excluded.
  localparam logic [ByteCntW-1:0] ByteLimit = 13'd8191;

  // Input transaction.
  typedef struct packed {
    logic [7:0] in_char;
    logic       line_end;
  } in_t;

  // Output transaction.
  typedef struct packed {
    logic [TabRunW-1:0]    tab_run;
    logic [SpaceRunW-1:0]  space_run;
    logic                  has_char;
    logic [7:0]            out_char;
    logic                  end_of_line;
    logic [LineBytesW-1:0] line_bytes;
    logic                  column_overflow;
  } out_t;

  // Classified placement handed from front to back, column travels beside it.
  typedef struct packed {
    logic       has_char;
    logic [7:0] out_char;
    logic       end_of_line;
    logic       col_ovf;
  } tag_t;

endpackage

`default_nettype wire

[hdl/text_line_export_entabber_top.sv]
// Top level of the text line export entabber.
`default_nettype none

// Converts internal-format line text to external text, one character per
// input transaction, and takes a new transaction every clock cycle unless the
// input is stalled. The front end decodes escapes, drops blanks and tracks the
// column in the accepting cycle; the two-entry queue then hands placements to
// the back end, which computes tab and space runs and the saturating byte
// count combinationally into the output register. A result is registered in
// the queue and then in the output register before it is offered. The input
// stalls only while the queue is full; under a steady input stream that starts
// in the cycle after the first stalled output cycle. Blanks and a lone escape
// give no result; the line-end transaction always gives one carrying the
// line's byte count.

module text_line_export_entabber_top #(
  parameter int unsigned MaxColumn = tlent_pkg::DefMaxColumn
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire tlent_pkg::in_t in_data_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output tlent_pkg::out_t out_data_o
);

  localparam int unsigned ColW = $clog2(MaxColumn + 1);
  localparam int unsigned TagW = $bits(tlent_pkg::tag_t);
  localparam int unsigned QW   = ColW + TagW;

  logic            push;
  logic [ColW-1:0] push_col;
  tlent_pkg::tag_t push_tag;
  logic            q_full;
  logic            q_valid;
  logic [QW-1:0]   q_data;
  logic            q_pop;
  tlent_pkg::tag_t q_tag;
  logic [ColW-1:0] q_col;

  tlent_front #(.MaxColumn(MaxColumn)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_col_o (push_col),
    .push_tag_o (push_tag)
  );

  tlent_queue #(.Width(QW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_tag, push_col}),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (q_pop)
  );

  assign q_tag = q_data[QW-1:ColW];
  assign q_col = q_data[ColW-1:0];

  tlent_back #(.MaxColumn(MaxColumn)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_col_i     (q_col),
    .q_tag_i     (q_tag),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[hdl/tlent_front.sv]
// Front end: escape decoding, blank filtering and column tracking.
`default_nettype none

module tlent_front #(
  parameter int unsigned MaxColumn = tlent_pkg::DefMaxColumn,
  localparam int unsigned ColW = $clog2(MaxColumn + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire tlent_pkg::in_t  in_data_i,
  output logic                 in_stall_o,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output logic [ColW-1:0]      push_col_o,
  output tlent_pkg::tag_t      push_tag_o
);

  localparam logic [ColW-1:0] MaxCol = ColW'(MaxColumn);

  logic [ColW-1:0] col_q, col_d;
  logic            esc_q, esc_d;
  logic            ovf_q, ovf_d;
  logic            accept;
  logic            sat;
  logic [ColW-1:0] col_inc;
  logic [7:0]      ch_masked;

  // Stall only when the queue has no room.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // Saturating column advance.
  assign sat       = (col_q == MaxCol);
  assign col_inc   = sat ? col_q : col_q + 1'b1;
  assign ch_masked = esc_q ? (in_data_i.in_char & tlent_pkg::CtrlMask) : in_data_i.in_char;

  // Classify the accepted transaction.
  always_comb begin
    col_d      = col_q;
    esc_d      = esc_q;
    ovf_d      = ovf_q;
    push_o     = 1'b0;
    push_col_o = '0;
    push_tag_o = '0;
    if (accept) begin
      priority if (in_data_i.line_end) begin
        push_o                 = 1'b1;
        push_tag_o.end_of_line = 1'b1;
        push_tag_o.col_ovf     = ovf_q;
        // A dangling escape is taken literally at line end.
        if (esc_q) begin
          push_col_o          = col_q;
          push_tag_o.has_char = 1'b1;
          push_tag_o.out_char = tlent_pkg::EscChar;
          push_tag_o.col_ovf  = ovf_q | sat;
        end
        col_d = '0;
        esc_d = 1'b0;
        ovf_d = 1'b0;
      end else if (!esc_q && in_data_i.in_char == tlent_pkg::EscChar) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        col_d = col_inc;
        ovf_d = ovf_q | sat;
        // Drop blanks; they only advance the column.
        if (ch_masked != tlent_pkg::SpaceChar) begin
          push_o              = 1'b1;
          push_col_o          = col_q;
          push_tag_o.has_char = 1'b1;
          push_tag_o.out_char = ch_masked;
          push_tag_o.col_ovf  = ovf_q | sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      esc_q <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      col_q <= col_d;
      esc_q <= esc_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

[hdl/tlent_queue.sv]
// Two-entry queue between front end and back end.
`default_nettype none

module tlent_queue #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  full_o,
  output logic                  valid_o,
  output logic [Width-1:0]      data_o,
  input  wire logic             pop_i
);

  localparam int unsigned Depth = 2;

  logic [Width-1:0] mem_q [Depth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'(Depth));
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Store entries.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/tlent_back.sv]
// Back end: run counts, byte accounting and the output register.
`default_nettype none

module tlent_back #(
  parameter int unsigned MaxColumn = tlent_pkg::DefMaxColumn,
  localparam int unsigned ColW = $clog2(MaxColumn + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire logic [ColW-1:0] q_col_i,
  input  wire tlent_pkg::tag_t q_tag_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tlent_pkg::out_t    out_data_o
);

  localparam int unsigned EmitW = $clog2(MaxColumn + 2);
  localparam int unsigned RunW  = (ColW > tlent_pkg::SpaceRunW) ? ColW : tlent_pkg::SpaceRunW;
  localparam int unsigned SumW  =
      ((RunW + 2 > tlent_pkg::ByteCntW) ? RunW + 2 : tlent_pkg::ByteCntW) + 1;

  logic [EmitW-1:0]              emit_q;
  logic [tlent_pkg::ByteCntW-1:0] byte_q;
  logic                          bovf_q;
  logic                          out_valid_q;
  tlent_pkg::out_t               out_q;

  logic [EmitW-1:0]              col_e;
  logic [RunW-1:0]               tabs_w, spaces_w;
  logic [SumW-1:0]               sum;
  logic                          bsat;
  logic [tlent_pkg::ByteCntW-1:0] bytes_new;
  logic [tlent_pkg::ByteCntW-1:0] bytes_upd;
  tlent_pkg::out_t               res;

  // Take from the queue whenever the output register is free or draining.
  assign q_pop_o = q_valid_i & (~out_valid_q | ~out_stall_i);

  // Runs: tabs then spaces before the first character, spaces after.
  assign col_e = EmitW'(q_col_i);
  always_comb begin
    tabs_w   = '0;
    spaces_w = '0;
    if (q_tag_i.has_char) begin
      if (emit_q == '0) begin
        tabs_w   = RunW'(q_col_i >> tlent_pkg::TabShift);
        spaces_w = RunW'(q_col_i & ColW'(tlent_pkg::TabStop - 1));
      end else if (col_e >= emit_q) begin
        spaces_w = RunW'(col_e - emit_q);
      end
    end
  end

  // Saturating byte count.
  assign sum = q_tag_i.has_char
             ? SumW'(byte_q) + SumW'(tabs_w) + SumW'(spaces_w) + SumW'(1)
             : SumW'(byte_q);
  assign bsat      = (sum > SumW'(tlent_pkg::ByteLimit));
  assign bytes_new = bsat ? tlent_pkg::ByteLimit : sum[tlent_pkg::ByteCntW-1:0];
  assign bytes_upd = bytes_new;

  // Assemble the result.
  always_comb begin
    res                 = '0;
    res.tab_run         = tabs_w[tlent_pkg::TabRunW-1:0];
    res.space_run       = spaces_w[tlent_pkg::SpaceRunW-1:0];
    res.has_char        = q_tag_i.has_char;
    res.out_char        = q_tag_i.out_char;
    res.end_of_line     = q_tag_i.end_of_line;
    res.line_bytes      = q_tag_i.end_of_line
                        ? tlent_pkg::LineBytesW'(bytes_upd) + 1'b1 : '0;
    res.column_overflow = bovf_q | bsat | q_tag_i.col_ovf;
  end

  // Hold line state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q      <= '0;
      byte_q      <= '0;
      bovf_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
        if (q_tag_i.end_of_line) begin
          emit_q <= '0;
          byte_q <= '0;
          bovf_q <= 1'b0;
        end else begin
          emit_q <= col_e + 1'b1;
          byte_q <= bytes_upd;
          bovf_q <= bovf_q | bsat;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[hdl/tlent_checker.sv]
// Port-level checks of the entabber and their binding to the top level.
`default_nettype none

module tlent_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire tlent_pkg::in_t in_data_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire tlent_pkg::out_t out_data_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // Only the line-end transaction may come without a character.
  a_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_char |->
      out_data_o.end_of_line && out_data_o.out_char == 8'd0 &&
      out_data_o.tab_run == '0 && out_data_o.space_run == '0)
    else $error("characterless result is not a bare line end");

  // Byte count appears on line end only, and counts the newline.
  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.end_of_line && out_data_o.line_bytes != '0) ||
      (!out_data_o.end_of_line && out_data_o.line_bytes == '0))
    else $error("line byte count misplaced");

  // A line end into an empty pipeline passes queue and output register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.line_end && !out_valid_o &&
    $past(!(in_valid_i && !in_stall_o)) |-> ##2 out_valid_o)
    else $error("line end result did not appear");

endmodule

bind text_line_export_entabber_top tlent_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_data_i   (in_data_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[tb/testbench.sv]
// Testbench of the text line export entabber: directed and random lines checked against a column tracker.
`default_nettype none

module testbench;

  localparam int unsigned MaxColumn  = tlent_pkg::DefMaxColumn;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 120;

  // Track the column and byte count of the current line and queue the runs expected.
  class line_checker;
    int unsigned       next_col;
    int unsigned       emitted_col;
    int unsigned       byte_total;
    bit                esc_wait;
    bit                ovf_seen;
    tlent_pkg::out_t   expected_q[$];
    int unsigned       mismatches;

    function new();
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      next_col    = 0;
      emitted_col = 0;
      byte_total  = 0;
      esc_wait    = 1'b0;
      ovf_seen    = 1'b0;
    endfunction

    // Hand out the current column, pinning it at the bound.
    function int unsigned claim_column();
      int unsigned col;
      col = next_col;
      if (next_col < MaxColumn) next_col++;
      else ovf_seen = 1'b1;
      return col;
    endfunction

    // Work out the tab and space runs that bring the output to column col.
    function tlent_pkg::out_t place(int unsigned col, logic [7:0] ch, bit eol);
      int unsigned     tabs;
      int unsigned     spaces;
      int unsigned     room;
      tlent_pkg::out_t r;
      tabs   = 0;
      spaces = 0;
      if (emitted_col == 0) begin
        tabs   = col / tlent_pkg::TabStop;
        spaces = col % tlent_pkg::TabStop;
      end else if (col >= emitted_col) begin
        spaces = col - emitted_col;
      end
      emitted_col = col + 1;
      room = tlent_pkg::ByteLimit - byte_total;
      if (tabs + spaces + 1 > room) begin
        byte_total = tlent_pkg::ByteLimit;
        ovf_seen   = 1'b1;
      end else begin
        byte_total += tabs + spaces + 1;
      end
      r                 = '0;
      r.tab_run         = tabs[tlent_pkg::TabRunW-1:0];
      r.space_run       = spaces[tlent_pkg::SpaceRunW-1:0];
      r.has_char        = 1'b1;
      r.out_char        = ch;
      r.end_of_line     = eol;
      r.column_overflow = ovf_seen;
      return r;
    endfunction

    // Note an accepted input transaction.
    function void accept_char(tlent_pkg::in_t item);
      logic [7:0]      c;
      int unsigned     col;
      tlent_pkg::out_t r;
      int unsigned     total;
      if (item.line_end) begin
        if (esc_wait) begin
          r = place(claim_column(), tlent_pkg::EscChar, 1'b1);
        end else begin
          r                 = '0;
          r.end_of_line     = 1'b1;
          r.column_overflow = ovf_seen;
        end
        total        = byte_total + 1;
        r.line_bytes = total[tlent_pkg::LineBytesW-1:0];
        expected_q.push_back(r);
        clear_line();
        return;
      end
      c = item.in_char;
      if (!esc_wait && c == tlent_pkg::EscChar) begin
        esc_wait = 1'b1;
        return;
      end
      if (esc_wait) begin
        c        = c & tlent_pkg::CtrlMask;
        esc_wait = 1'b0;
      end
      col = claim_column();
      if (c != tlent_pkg::SpaceChar) expected_q.push_back(place(col, c, 1'b0));
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    // Check an accepted output transaction against the oldest expectation.
    function void check_output(tlent_pkg::out_t got);
      tlent_pkg::out_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output, expected none got %p", $time, got);
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("tab_run", exp_r.tab_run, got.tab_run);
      compare_field("space_run", exp_r.space_run, got.space_run);
      compare_field("has_char", exp_r.has_char, got.has_char);
      compare_field("out_char", exp_r.out_char, got.out_char);
      compare_field("end_of_line", exp_r.end_of_line, got.end_of_line);
      compare_field("line_bytes", exp_r.line_bytes, got.line_bytes);
      compare_field("column_overflow", exp_r.column_overflow, got.column_overflow);
    endfunction

    function int unsigned num_waiting();
      return expected_q.size();
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  tlent_pkg::in_t  in_data_i;
  logic            in_stall_o;
  logic            out_valid_o;
  logic            out_stall_i;
  tlent_pkg::out_t out_data_o;

  line_checker chk = new();

  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_request;

  text_line_export_entabber_top #(.MaxColumn(MaxColumn)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Count cycles and record every transaction on both channels.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) chk.check_output(out_data_o);
      if (in_valid_i && !in_stall_o) chk.accept_char(in_data_i);
    end
  end

  // End the run on a hung block.
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  // Stall the output at random, or hold it off for a long stretch on request.
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // Offer one input transaction, idling first at random; call and return at a falling edge.
  task automatic send_item(logic [7:0] c, logic eol);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_data_i.in_char  <= c;
    in_data_i.line_end <= eol;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_char(bit no_blanks);
    int unsigned k;
    logic [7:0]  c;
    k = $urandom_range(0, 99);
    if (k < 25) c = tlent_pkg::SpaceChar;
    else if (k < 33) c = tlent_pkg::EscChar;
    else if (k < 70) c = 8'($urandom_range(33, 126));
    else c = 8'($urandom_range(0, 255));
    if (no_blanks && (c == tlent_pkg::SpaceChar || c == tlent_pkg::EscChar)) begin
      c = 8'($urandom_range(33, 126));
    end
    return c;
  endfunction

  // Send a line of random content, sometimes with a dangling escape before its end.
  task automatic send_line(int unsigned len, bit no_blanks);
    for (int unsigned i = 0; i < len; i++) send_item(random_char(no_blanks), 1'b0);
    if ($urandom_range(0, 99) < 15) send_item(tlent_pkg::EscChar, 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_random_lines(int unsigned until_items);
    int unsigned len;
    while (items_sent < until_items) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(40, 120);
      else len = $urandom_range(0, 24);
      send_line(len, 1'b0);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    items_sent   = 0;
    tx_idle_pct  = 30;
    rx_idle_pct  = 30;
    hold_request = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty line, its ignored character all ones.
    send_item(8'hFF, 1'b1);
    // Leading blanks past a tab stop, then trailing blanks to drop.
    repeat (9) send_item(tlent_pkg::SpaceChar, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(tlent_pkg::SpaceChar, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(tlent_pkg::SpaceChar, 1'b0);
    send_item(tlent_pkg::SpaceChar, 1'b0);
    send_item(8'h00, 1'b1);
    // Newline code as data, escape pairs, escaped blank, escape before line end.
    send_item(8'h0A, 1'b0);
    send_item(tlent_pkg::EscChar, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(tlent_pkg::EscChar, 1'b0);
    send_item(tlent_pkg::EscChar, 1'b0);
    send_item(tlent_pkg::EscChar, 1'b0);
    send_item(tlent_pkg::SpaceChar, 1'b0);
    send_item(tlent_pkg::EscChar, 1'b0);
    send_item(8'h00, 1'b1);

    // Random lines with idling on both sides and one long output hold-off.
    send_random_lines(items_sent + 300);
    hold_request = 1'b1;
    send_random_lines(items_sent + 400);

    // Long stretch without idling.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_lines(items_sent + 450);

    // More random lines with idling on both sides.
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    send_random_lines(items_sent + 400);

    // Drain, then give the block time to show any stray output.
    in_valid_i <= 1'b0;
    while (chk.num_waiting() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (chk.mismatches == 0 && chk.num_waiting() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
